/* sv/sfr_pkg.sv */
// Shared types and constants for the stuffed frame receiver.
package sfr_pkg;

	localparam int BYTE_W   = 8;
	localparam int POS_W    = 10;
	localparam int LEN_W    = 11;
	localparam int STATUS_W = 2;
	localparam int PADDR_W  = 5;
	localparam int PDATA_W  = 32;

	// Frame status codes reported with every result.
	localparam logic [STATUS_W-1:0] ST_BUSY = 2'd0;
	localparam logic [STATUS_W-1:0] ST_DONE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FAIL = 2'd2;

	// Configuration register indexes (word address on the APB port).
	typedef enum logic [2:0] {
		REG_FLAG     = 3'd0,
		REG_ADDRESS  = 3'd1,
		REG_CTRL_A   = 3'd2,
		REG_CTRL_B   = 3'd3,
		REG_ESCAPE   = 3'd4,
		REG_ESC_FLAG = 3'd5,
		REG_ESC_ESC  = 3'd6
	} reg_idx_t;

	// Register reset values.
	localparam logic [BYTE_W-1:0] RST_FLAG     = 8'd126;
	localparam logic [BYTE_W-1:0] RST_ADDRESS  = 8'd3;
	localparam logic [BYTE_W-1:0] RST_CTRL_A   = 8'd0;
	localparam logic [BYTE_W-1:0] RST_CTRL_B   = 8'd64;
	localparam logic [BYTE_W-1:0] RST_ESCAPE   = 8'd125;
	localparam logic [BYTE_W-1:0] RST_ESC_FLAG = 8'd94;
	localparam logic [BYTE_W-1:0] RST_ESC_ESC  = 8'd93;

	// Current configuration as seen by the frame logic.
	typedef struct packed {
		logic [BYTE_W-1:0] flag_value;
		logic [BYTE_W-1:0] address_value;
		logic [BYTE_W-1:0] control_first;
		logic [BYTE_W-1:0] control_second;
		logic [BYTE_W-1:0] escape_value;
		logic [BYTE_W-1:0] escaped_flag_value;
		logic [BYTE_W-1:0] escaped_escape_value;
	} cfg_t;

	// One result transaction.
	typedef struct packed {
		logic [STATUS_W-1:0] frame_status;
		logic                byte_stored;
		logic [BYTE_W-1:0]   stored_byte;
		logic [POS_W-1:0]    stored_position;
		logic [LEN_W-1:0]    payload_length;
		logic [BYTE_W-1:0]   control_seen;
	} res_t;

endpackage

/* sv/sfr_in_if.sv */
// Input channel: one received line byte per transaction.
interface sfr_in_if;
	import sfr_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] line_byte;
	logic              start_over;

	modport source (output valid, output line_byte, output start_over, input ready);
	modport sink (input valid, input line_byte, input start_over, output ready);
endinterface

/* sv/sfr_out_if.sv */
// Output channel: one status result per transaction.
interface sfr_out_if;
	import sfr_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] frame_status;
	logic                byte_stored;
	logic [BYTE_W-1:0]   stored_byte;
	logic [POS_W-1:0]    stored_position;
	logic [LEN_W-1:0]    payload_length;
	logic [BYTE_W-1:0]   control_seen;

	modport source (output valid, output frame_status, output byte_stored, output stored_byte,
		output stored_position, output payload_length, output control_seen, input ready);
	modport sink (input valid, input frame_status, input byte_stored, input stored_byte,
		input stored_position, input payload_length, input control_seen, output ready);
endinterface

/* sv/sfr_ram.sv */
// Generic single-port-write, registered-read RAM.
module sfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

/* sv/sfr_regs.sv */
// APB configuration registers of the stuffed frame receiver.
module sfr_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [sfr_pkg::PADDR_W-1:0]     paddr,
	input  logic [sfr_pkg::PDATA_W-1:0]     pwdata,
	output logic [sfr_pkg::PDATA_W-1:0]     prdata,
	output logic                            pready,
	output sfr_pkg::cfg_t                   cfg
);
	import sfr_pkg::*;

	cfg_t              cfg_q;
	logic              wr_en;
	logic [2:0]        idx;
	logic [BYTE_W-1:0] wbyte;
	logic [BYTE_W-1:0] rbyte;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[PADDR_W-1:2];
	assign wbyte  = pwdata[BYTE_W-1:0];

	// Register write on the access phase of an APB write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.flag_value           <= RST_FLAG;
			cfg_q.address_value        <= RST_ADDRESS;
			cfg_q.control_first        <= RST_CTRL_A;
			cfg_q.control_second       <= RST_CTRL_B;
			cfg_q.escape_value         <= RST_ESCAPE;
			cfg_q.escaped_flag_value   <= RST_ESC_FLAG;
			cfg_q.escaped_escape_value <= RST_ESC_ESC;
		end else if (wr_en) begin
			unique case (idx)
				REG_FLAG:     cfg_q.flag_value           <= wbyte;
				REG_ADDRESS:  cfg_q.address_value        <= wbyte;
				REG_CTRL_A:   cfg_q.control_first        <= wbyte;
				REG_CTRL_B:   cfg_q.control_second       <= wbyte;
				REG_ESCAPE:   cfg_q.escape_value         <= wbyte;
				REG_ESC_FLAG: cfg_q.escaped_flag_value   <= wbyte;
				REG_ESC_ESC:  cfg_q.escaped_escape_value <= wbyte;
				default: ;
			endcase
		end
	end

	// Read mux.
	always_comb begin
		unique case (idx)
			REG_FLAG:     rbyte = cfg_q.flag_value;
			REG_ADDRESS:  rbyte = cfg_q.address_value;
			REG_CTRL_A:   rbyte = cfg_q.control_first;
			REG_CTRL_B:   rbyte = cfg_q.control_second;
			REG_ESCAPE:   rbyte = cfg_q.escape_value;
			REG_ESC_FLAG: rbyte = cfg_q.escaped_flag_value;
			REG_ESC_ESC:  rbyte = cfg_q.escaped_escape_value;
			default:      rbyte = '0;
		endcase
	end

	assign prdata = {{(PDATA_W-BYTE_W){1'b0}}, rbyte};
	assign cfg    = cfg_q;
endmodule

/* sv/sfr_core.sv */
// Frame state, de-stuffing, parity check and payload store write request.
module sfr_core #(
	parameter int PAYLOAD_DEPTH = 1024,
	parameter int AW            = 10
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic [sfr_pkg::BYTE_W-1:0]   line_byte,
	input  logic                         start_over,
	input  sfr_pkg::cfg_t                cfg,
	output sfr_pkg::res_t                res,
	output logic                         we,
	output logic [AW-1:0]                waddr,
	output logic [sfr_pkg::BYTE_W-1:0]   wdata
);
	import sfr_pkg::*;

	localparam int CNT_W = $clog2(PAYLOAD_DEPTH + 1);

	typedef enum logic [8:0] {
		PH_HUNT = 9'b000000001,
		PH_FLAG = 9'b000000010,
		PH_ADDR = 9'b000000100,
		PH_CTRL = 9'b000001000,
		PH_HDR  = 9'b000010000,
		PH_DATA = 9'b000100000,
		PH_ESC  = 9'b001000000,
		PH_DONE = 9'b010000000,
		PH_FAIL = 9'b100000000
	} phase_t;

	phase_t            phase_q, phase_d;
	logic [BYTE_W-1:0] ctrl_q, ctrl_d;
	logic [BYTE_W-1:0] parity_q, parity_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic              put_req;
	logic [BYTE_W-1:0] put_data;
	logic              stored;

	// Next-state logic for one line byte.
	always_comb begin
		phase_d  = phase_q;
		ctrl_d   = ctrl_q;
		parity_d = parity_q;
		count_d  = count_q;
		put_req  = 1'b0;
		put_data = line_byte;
		stored   = 1'b0;
		if (start_over) begin
			phase_d  = PH_HUNT;
			ctrl_d   = '0;
			parity_d = '0;
			count_d  = '0;
		end else begin
			unique case (phase_q)
				PH_HUNT: begin
					if (line_byte == cfg.flag_value) phase_d = PH_FLAG;
				end
				PH_FLAG: begin
					if (line_byte == cfg.address_value) phase_d = PH_ADDR;
					else if (line_byte == cfg.flag_value) phase_d = PH_FLAG;
					else phase_d = PH_HUNT;
				end
				PH_ADDR: begin
					if (line_byte == cfg.control_first || line_byte == cfg.control_second) begin
						ctrl_d  = line_byte;
						phase_d = PH_CTRL;
					end else if (line_byte == cfg.flag_value) begin
						phase_d = PH_FLAG;
					end else begin
						phase_d = PH_HUNT;
					end
				end
				PH_CTRL: begin
					if (line_byte == (cfg.address_value ^ ctrl_q)) phase_d = PH_HDR;
					else if (line_byte == cfg.flag_value) phase_d = PH_FLAG;
					else phase_d = PH_HUNT;
				end
				PH_HDR: begin
					if (line_byte == cfg.flag_value) phase_d = PH_FAIL;
					else if (line_byte == cfg.escape_value) phase_d = PH_ESC;
					else put_req = 1'b1;
				end
				PH_DATA: begin
					if (line_byte == cfg.flag_value) begin
						if (parity_q == '0) begin
							if (count_q != '0) count_d = count_q - 1'b1;
							phase_d = PH_DONE;
						end else begin
							phase_d = PH_FAIL;
						end
					end else if (line_byte == cfg.escape_value) begin
						phase_d = PH_ESC;
					end else begin
						put_req = 1'b1;
					end
				end
				PH_ESC: begin
					if (line_byte == cfg.escaped_flag_value) begin
						put_req  = 1'b1;
						put_data = cfg.flag_value;
					end else if (line_byte == cfg.escaped_escape_value) begin
						put_req  = 1'b1;
						put_data = cfg.escape_value;
					end else begin
						phase_d = PH_FAIL;
					end
				end
				PH_DONE, PH_FAIL: ;
				default: phase_d = PH_HUNT;
			endcase

			// Store a de-stuffed byte, or fail when the store is full.
			if (put_req) begin
				if (count_q == CNT_W'(PAYLOAD_DEPTH)) begin
					phase_d = PH_FAIL;
				end else begin
					stored   = 1'b1;
					count_d  = count_q + 1'b1;
					parity_d = parity_q ^ put_data;
					phase_d  = PH_DATA;
				end
			end
		end
	end

	// Frame state registers advance once per processed byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			ctrl_q   <= '0;
			parity_q <= '0;
			count_q  <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			ctrl_q   <= ctrl_d;
			parity_q <= parity_d;
			count_q  <= count_d;
		end
	end

	// Payload store write.
	assign we    = step && stored;
	assign waddr = count_q[AW-1:0];
	assign wdata = put_data;

	// Result of this step.
	always_comb begin
		if (phase_d == PH_DONE) res.frame_status = ST_DONE;
		else if (phase_d == PH_FAIL) res.frame_status = ST_FAIL;
		else res.frame_status = ST_BUSY;
		res.byte_stored     = stored;
		res.stored_byte     = stored ? put_data : '0;
		res.stored_position = stored ? POS_W'(count_q) : '0;
		res.payload_length  = LEN_W'(count_d);
		res.control_seen    = ctrl_d;
	end
endmodule

/* sv/stuffed_frame_receiver.sv */
// Top level of the stuffed frame receiver.
//
// The in_ch channel carries one received line byte per transaction, with
// start_over set to return the receiver to hunting for an opening flag.
// Every input transaction produces exactly one result transaction on out_ch:
// frame status, the de-stuffed byte stored in this step with its position,
// the payload length so far and the accepted control byte.
// A byte is captured in an input register, processed by one pass of the
// frame logic and written to the result register. One byte is taken every
// cycle while out_ch is ready; the frame state updates once per byte.
// When out_ch stalls, the result register holds and the input register
// fills, after which in_ch.ready drops until the result is taken.
// Reset clears both registers' valid bits, the frame state and the
// configuration registers; the payload store needs no clearing.
// Configuration is to be written over APB by the user only while no
// transaction is in flight; the block itself does not enforce this.
module stuffed_frame_receiver #(
	parameter int PAYLOAD_DEPTH = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	sfr_in_if.sink                       in_ch,
	sfr_out_if.source                    out_ch,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [sfr_pkg::PADDR_W-1:0]  paddr,
	input  logic [sfr_pkg::PDATA_W-1:0]  pwdata,
	output logic [sfr_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);
	import sfr_pkg::*;

	localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

	cfg_t              cfg;
	res_t              res;
	res_t              res_s2;
	logic              vld_s1, vld_s2;
	logic [BYTE_W-1:0] line_byte_s1;
	logic              start_over_s1;
	logic              step;
	logic              in_take;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [BYTE_W-1:0] ram_wdata;

	// Handshake: process the held byte whenever the result register is free.
	assign step        = vld_s1 && (!vld_s2 || out_ch.ready);
	assign in_ch.ready = !vld_s1 || step;
	assign in_take     = in_ch.valid && in_ch.ready;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_take) begin
			vld_s1 <= 1'b1;
		end else if (step) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			line_byte_s1  <= in_ch.line_byte;
			start_over_s1 <= in_ch.start_over;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (step) begin
			vld_s2 <= 1'b1;
		end else if (out_ch.ready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= res;
		end
	end

	assign out_ch.valid           = vld_s2;
	assign out_ch.frame_status    = res_s2.frame_status;
	assign out_ch.byte_stored     = res_s2.byte_stored;
	assign out_ch.stored_byte     = res_s2.stored_byte;
	assign out_ch.stored_position = res_s2.stored_position;
	assign out_ch.payload_length  = res_s2.payload_length;
	assign out_ch.control_seen    = res_s2.control_seen;

	// Configuration registers.
	sfr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Frame logic.
	sfr_core #(
		.PAYLOAD_DEPTH (PAYLOAD_DEPTH),
		.AW            (AW)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.line_byte  (line_byte_s1),
		.start_over (start_over_s1),
		.cfg        (cfg),
		.res        (res),
		.we         (ram_we),
		.waddr      (ram_waddr),
		.wdata      (ram_wdata)
	);

	// Payload store.
	sfr_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (PAYLOAD_DEPTH)
	) u_payload (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_waddr),
		.rdata ()
	);
endmodule

/* verif/testbench.sv */
// Self-checking testbench for the stuffed frame receiver: directed and random frames.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import sfr_pkg::*;

	localparam int DEPTH       = 1024;
	localparam int ITEM_TARGET = 1950;
	localparam int IDLE_LIMIT  = 5000;
	localparam int MAX_REPORTS = 10;

	typedef logic [BYTE_W-1:0] byte_q_t[$];

	typedef enum logic [3:0] {
		RX_HUNT, RX_FLAG, RX_ADDR, RX_CTRL, RX_HDR, RX_DATA, RX_ESC, RX_DONE, RX_FAIL
	} rx_phase_t;

	// Field order follows cfg_t: flag, address, two controls, escape, two escaped codes.
	localparam cfg_t CFG_RESET = {RST_FLAG, RST_ADDRESS, RST_CTRL_A, RST_CTRL_B,
		RST_ESCAPE, RST_ESC_FLAG, RST_ESC_ESC};
	localparam cfg_t CORNER_CFGS [3] = '{
		{8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF},
		{8'h5A, 8'h5A, 8'h5A, 8'h5A, 8'h5A, 8'h5A, 8'h5A},
		{8'h30, 8'h10, 8'h20, 8'h30, 8'h31, 8'h07, 8'h07}
	};

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	sfr_in_if  in_ch();
	sfr_out_if out_ch();

	stuffed_frame_receiver #(.PAYLOAD_DEPTH(DEPTH)) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Receiver state as predicted from the accepted line bytes.
	cfg_t              cfg;
	rx_phase_t         rx_phase;
	logic [BYTE_W-1:0] ctl_latch;
	logic [BYTE_W-1:0] xor_acc;
	logic [LEN_W-1:0]  stored_cnt;

	res_t    results_due[$];
	byte_q_t line_q;
	int      items_sent  = 0;
	int      fail_cnt    = 0;
	int      idle_cycles = 0;
	int      burst_left  = 0;
	int      stall_pct   = 0;
	int      stall_epoch = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Store one de-stuffed byte, or fail the frame when the store is full.
	function automatic void store_payload(input logic [BYTE_W-1:0] b, inout res_t r);
		if (stored_cnt >= DEPTH) begin
			rx_phase = RX_FAIL;
		end else begin
			r.byte_stored     = 1'b1;
			r.stored_byte     = b;
			r.stored_position = stored_cnt[POS_W-1:0];
			stored_cnt++;
			xor_acc ^= b;
			rx_phase = RX_DATA;
		end
	endfunction

	// Advance the predicted receiver by one line byte and return the status it reports.
	function automatic res_t advance_receiver(input logic [BYTE_W-1:0] b, input logic restart);
		res_t r;
		r = '0;
		if (restart) begin
			rx_phase   = RX_HUNT;
			ctl_latch  = '0;
			xor_acc    = '0;
			stored_cnt = '0;
		end else begin
			case (rx_phase)
			RX_HUNT: begin
				if (b == cfg.flag_value) rx_phase = RX_FLAG;
			end
			RX_FLAG: begin
				if (b == cfg.address_value) rx_phase = RX_ADDR;
				else if (b != cfg.flag_value) rx_phase = RX_HUNT;
			end
			RX_ADDR: begin
				if (b == cfg.control_first || b == cfg.control_second) begin
					ctl_latch = b;
					rx_phase  = RX_CTRL;
				end else if (b == cfg.flag_value) begin
					rx_phase = RX_FLAG;
				end else begin
					rx_phase = RX_HUNT;
				end
			end
			RX_CTRL: begin
				if (b == (cfg.address_value ^ ctl_latch)) rx_phase = RX_HDR;
				else if (b == cfg.flag_value) rx_phase = RX_FLAG;
				else rx_phase = RX_HUNT;
			end
			RX_HDR: begin
				if (b == cfg.flag_value) rx_phase = RX_FAIL;
				else if (b == cfg.escape_value) rx_phase = RX_ESC;
				else store_payload(b, r);
			end
			RX_DATA: begin
				if (b == cfg.flag_value) begin
					// The check byte is dropped from the length of a good frame.
					if (xor_acc == '0) begin
						if (stored_cnt != '0) stored_cnt--;
						rx_phase = RX_DONE;
					end else begin
						rx_phase = RX_FAIL;
					end
				end else if (b == cfg.escape_value) begin
					rx_phase = RX_ESC;
				end else begin
					store_payload(b, r);
				end
			end
			RX_ESC: begin
				if (b == cfg.escaped_flag_value) store_payload(cfg.flag_value, r);
				else if (b == cfg.escaped_escape_value) store_payload(cfg.escape_value, r);
				else rx_phase = RX_FAIL;
			end
			RX_DONE, RX_FAIL: ;
			default: rx_phase = RX_HUNT;
			endcase
		end
		r.frame_status   = (rx_phase == RX_DONE) ? ST_DONE :
			(rx_phase == RX_FAIL) ? ST_FAIL : ST_BUSY;
		r.payload_length = stored_cnt;
		r.control_seen   = ctl_latch;
		return r;
	endfunction

	function automatic void note_failure(input string what, input res_t want, input res_t got);
		fail_cnt++;
		if (fail_cnt <= MAX_REPORTS) begin
			$display("%0t: %s (status/stored/byte/position/length/control)", $realtime, what);
			$display("  expected %0d/%0b/%02h/%0d/%0d/%02h", want.frame_status,
				want.byte_stored, want.stored_byte, want.stored_position,
				want.payload_length, want.control_seen);
			$display("  actual   %0d/%0b/%02h/%0d/%0d/%02h", got.frame_status,
				got.byte_stored, got.stored_byte, got.stored_position,
				got.payload_length, got.control_seen);
		end
	endfunction

	// Each result transaction is compared with the oldest expectation.
	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = {out_ch.frame_status, out_ch.byte_stored, out_ch.stored_byte,
				out_ch.stored_position, out_ch.payload_length, out_ch.control_seen};
			if (results_due.size() == 0) begin
				note_failure("result with nothing expected", '0, got);
			end else begin
				want = results_due.pop_front();
				if (got.frame_status !== want.frame_status ||
					got.byte_stored !== want.byte_stored ||
					got.stored_byte !== want.stored_byte ||
					got.stored_position !== want.stored_position ||
					got.payload_length !== want.payload_length ||
					got.control_seen !== want.control_seen)
					note_failure("result mismatch", want, got);
			end
		end
	end

	// The result side stalls in epochs: some with no stalls, some light, some heavy.
	always @(posedge clk) begin
		if (stall_epoch == 0) begin
			stall_epoch = $urandom_range(50, 400);
			case ($urandom_range(0, 3))
			0: stall_pct = 0;
			1: stall_pct = 20;
			2: stall_pct = 50;
			default: stall_pct = 85;
			endcase
		end
		stall_epoch--;
		out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// Watchdog: ends the run when no transaction completes for too long.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
			(psel && penable && pready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Watchdog expired after %0d cycles without a transaction", IDLE_LIMIT);
			$display("Some tests failed");
			$finish;
		end
	end

	// Send one line byte in bursts with random gaps; predict its result on acceptance.
	task automatic send_line(input logic [BYTE_W-1:0] b, input logic restart);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_ch.valid      <= 1'b1;
		in_ch.line_byte  <= b;
		in_ch.start_over <= restart;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		results_due.push_back(advance_receiver(b, restart));
		items_sent++;
	endtask

	// Stop sending and wait until every expected result has arrived.
	task automatic drain_results();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (results_due.size() != 0) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle until pready.
	task automatic write_register(input reg_idx_t idx, input logic [BYTE_W-1:0] value);
		logic [PDATA_W-1:0] word;
		drain_results();
		word = $urandom;
		word[BYTE_W-1:0] = value;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= word;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
		REG_FLAG:     cfg.flag_value           = value;
		REG_ADDRESS:  cfg.address_value        = value;
		REG_CTRL_A:   cfg.control_first        = value;
		REG_CTRL_B:   cfg.control_second       = value;
		REG_ESCAPE:   cfg.escape_value         = value;
		REG_ESC_FLAG: cfg.escaped_flag_value   = value;
		REG_ESC_ESC:  cfg.escaped_escape_value = value;
		default: ;
		endcase
	endtask

	task automatic apply_config(input cfg_t c);
		write_register(REG_FLAG, c.flag_value);
		write_register(REG_ADDRESS, c.address_value);
		write_register(REG_CTRL_A, c.control_first);
		write_register(REG_CTRL_B, c.control_second);
		write_register(REG_ESCAPE, c.escape_value);
		write_register(REG_ESC_FLAG, c.escaped_flag_value);
		write_register(REG_ESC_ESC, c.escaped_escape_value);
	endtask

	// Register value that is now and then an extreme or a copy of another register.
	function automatic logic [BYTE_W-1:0] reg_value(input logic [BYTE_W-1:0] other);
		case ($urandom_range(0, 9))
		0: return 8'h00;
		1: return 8'hFF;
		2: return other;
		default: return 8'($urandom);
		endcase
	endfunction

	function automatic cfg_t random_config();
		cfg_t c;
		if ($urandom_range(0, 2) == 0) return CFG_RESET;
		c.flag_value           = reg_value(8'h7E);
		c.address_value        = reg_value(c.flag_value);
		c.control_first        = reg_value(c.address_value);
		c.control_second       = reg_value(c.flag_value);
		c.escape_value         = reg_value(c.flag_value);
		c.escaped_flag_value   = reg_value(c.control_second);
		c.escaped_escape_value = reg_value(c.escaped_flag_value);
		return c;
	endfunction

	function automatic logic [BYTE_W-1:0] xor_of(input byte_q_t q);
		logic [BYTE_W-1:0] acc;
		acc = '0;
		foreach (q[i]) acc ^= q[i];
		return acc;
	endfunction

	// Mostly short payloads, a few long ones.
	function automatic int payload_size();
		int roll;
		roll = $urandom_range(0, 19);
		if (roll < 16) return $urandom_range(1, 8);
		if (roll < 19) return $urandom_range(9, 40);
		return $urandom_range(41, 200);
	endfunction

	// Random payload; a good one ends with the XOR of the bytes before it.
	function automatic byte_q_t random_body(input int n, input bit good);
		byte_q_t q;
		repeat (n - 1) q.push_back(8'($urandom));
		q.push_back(good ? xor_of(q) : 8'($urandom));
		return q;
	endfunction

	function automatic logic [BYTE_W-1:0] pick_control();
		return ($urandom_range(0, 1) == 1) ? cfg.control_second : cfg.control_first;
	endfunction

	// Line bytes of a whole frame under the current settings, stuffed and closed.
	function automatic void build_frame(input byte_q_t body, input logic [BYTE_W-1:0] ctl);
		line_q = '{cfg.flag_value, cfg.address_value, ctl, cfg.address_value ^ ctl};
		foreach (body[i]) begin
			if (body[i] == cfg.flag_value) begin
				line_q.push_back(cfg.escape_value);
				line_q.push_back(cfg.escaped_flag_value);
			end else if (body[i] == cfg.escape_value) begin
				line_q.push_back(cfg.escape_value);
				line_q.push_back(cfg.escaped_escape_value);
			end else begin
				line_q.push_back(body[i]);
			end
		end
		line_q.push_back(cfg.flag_value);
	endfunction

	// Restart the receiver, then send the built frame with optional stray restarts.
	task automatic send_frame(input int restart_odds);
		send_line(8'($urandom), 1'b1);
		foreach (line_q[i]) begin
			if (restart_odds > 0 && $urandom_range(1, restart_odds) == 1)
				send_line(8'($urandom), 1'b1);
			send_line(line_q[i], 1'b0);
		end
	endtask

	// Header hunting: repeated flags, flags in place of header bytes, and mismatches.
	task automatic test_header_hunt();
		send_line(8'h00, 1'b0);
		send_line(8'hFF, 1'b0);
		send_line(cfg.flag_value, 1'b0);
		send_line(cfg.flag_value, 1'b0);
		send_line(8'h55, 1'b0);
		send_line(cfg.flag_value, 1'b0);
		send_line(cfg.address_value, 1'b0);
		send_line(cfg.flag_value, 1'b0);
		send_line(cfg.address_value, 1'b0);
		send_line(8'h11, 1'b0);
		send_line(cfg.flag_value, 1'b0);
		send_line(cfg.address_value, 1'b0);
		send_line(cfg.control_second, 1'b0);
		send_line(cfg.flag_value, 1'b0);
		send_line(cfg.address_value, 1'b0);
		send_line(cfg.control_first, 1'b0);
		send_line(8'hAA, 1'b0);
	endtask

	// Good frames: both escape pairs and extreme bytes, then a lone zero byte.
	task automatic test_clean_frames();
		byte_q_t body;
		body = '{cfg.flag_value, cfg.escape_value, 8'hFF, 8'h00};
		body.push_back(xor_of(body));
		build_frame(body, cfg.control_second);
		send_frame(0);
		// A finished frame ignores everything up to the next restart.
		send_line(cfg.flag_value, 1'b0);
		build_frame('{8'h00}, cfg.control_first);
		send_frame(0);
	endtask

	// Failing frames and a restart in the middle of a frame.
	task automatic test_frame_errors();
		byte_q_t no_body;
		// Flag right after the header check byte.
		build_frame(no_body, cfg.control_first);
		send_frame(0);
		send_line(cfg.address_value, 1'b0);
		// Running XOR not zero at the closing flag.
		build_frame('{8'h12}, cfg.control_second);
		send_frame(0);
		// Escape followed by a byte that is neither escaped code.
		build_frame('{8'h34}, cfg.control_second);
		void'(line_q.pop_back());
		line_q.push_back(cfg.escape_value);
		line_q.push_back(8'h00);
		send_frame(0);
		// Escape followed by the flag.
		build_frame(no_body, cfg.control_first);
		void'(line_q.pop_back());
		line_q.push_back(cfg.escape_value);
		line_q.push_back(cfg.flag_value);
		send_frame(0);
		// Frame cut off; the next frame starts with a restart.
		build_frame('{8'h01}, cfg.control_first);
		void'(line_q.pop_back());
		send_frame(0);
		build_frame('{8'h01, 8'h01}, cfg.control_first);
		send_frame(0);
	endtask

	// Settings with extreme values and registers that collide with each other.
	task automatic test_register_extremes();
		foreach (CORNER_CFGS[k]) begin
			apply_config(CORNER_CFGS[k]);
			repeat (4) begin
				build_frame(random_body($urandom_range(1, 6), 1'b1), pick_control());
				send_frame(0);
			end
			repeat ($urandom_range(2, 6)) send_line(8'($urandom), 1'b0);
		end
	endtask

	// Fill the payload store and send one byte more than it holds.
	task automatic test_overflow();
		byte_q_t body;
		logic [BYTE_W-1:0] b;
		apply_config(CFG_RESET);
		repeat (DEPTH + 1) begin
			do b = 8'($urandom); while (b == cfg.flag_value || b == cfg.escape_value);
			body.push_back(b);
		end
		build_frame(body, pick_control());
		send_frame(0);
	endtask

	// Mostly well-formed random frames, some broken ones and some line noise.
	task automatic test_random_traffic();
		int mode;
		while (items_sent < ITEM_TARGET) begin
			if ($urandom_range(0, 7) == 0) apply_config(random_config());
			mode = $urandom_range(0, 9);
			if (mode == 9) begin
				repeat ($urandom_range(1, 8))
					send_line(8'($urandom), $urandom_range(0, 9) == 0);
			end else begin
				build_frame(random_body(payload_size(), mode != 7), pick_control());
				if (mode == 8) line_q[$urandom_range(0, line_q.size() - 1)] = 8'($urandom);
				if ($urandom_range(0, 3) == 0) line_q.push_front(cfg.flag_value);
				send_frame((mode == 6) ? 12 : 0);
			end
		end
	endtask

	task automatic finish_run();
		drain_results();
		repeat (20) @(posedge clk);
		if (fail_cnt == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	endtask

	initial begin
		arst_n           = 1'b0;
		in_ch.valid      = 1'b0;
		in_ch.line_byte  = '0;
		in_ch.start_over = 1'b0;
		out_ch.ready     = 1'b0;
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		cfg              = CFG_RESET;
		rx_phase         = RX_HUNT;
		ctl_latch        = '0;
		xor_acc          = '0;
		stored_cnt       = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_header_hunt();
		test_clean_frames();
		test_frame_errors();
		test_register_extremes();
		test_overflow();
		test_random_traffic();
		finish_run();
	end

endmodule

/* files.f */
sv/sfr_pkg.sv
sv/sfr_in_if.sv
sv/sfr_out_if.sv
sv/sfr_ram.sv
sv/sfr_regs.sv
sv/sfr_core.sv
sv/stuffed_frame_receiver.sv
verif/testbench.sv
